[rtl/cnr_pkg.sv]
// shared types, constants and helpers for the clamp and renormalize block
package cnr_pkg;

    // pixel width and default store depth
    localparam int PIXEL_BITS     = 16;
    localparam int MAX_PIXELS_DEF = 65536;

    // depth of the queue between the front and the back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

    // divider step counter width
    localparam int STEP_W = $clog2(PIXEL_BITS);

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // saturation bounds as raw bit patterns
    localparam logic [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
    localparam logic [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

    typedef logic signed [PIXEL_BITS-1:0] t_pixel;
    // clamped pixel: never negative, so the sign bit is not stored
    typedef logic [PIXEL_BITS-2:0] t_mag;

    // one drain job handed from the front to the back
    typedef struct packed {
        t_mag pixel;
        logic last;
        logic scale;
    } t_job;

    // width of the running sums for a given store depth
    function automatic int sum_width(input int max_pixels);
        return PIXEL_BITS + $clog2(max_pixels);
    endfunction

endpackage

[rtl/cnr_queue.sv]
// small job queue between the front and the back
module cnr_queue
    import cnr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_job                i_job,
    input  logic                i_pop,
    output t_job                o_job,
    output logic [QCOUNT_W-1:0] o_count
);

    t_job                r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCOUNT_W-1:0] r_count, n_count;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    assign o_job   = r_entry[r_rd_ptr];
    assign o_count = r_count;

endmodule

[rtl/cnr_front.sv]
// input side: loads pixels into the store, keeps the sums, issues drain jobs
module cnr_front
    import cnr_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_operation,
    input  t_pixel                            i_pixel_value,
    input  logic                              i_is_last,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_wdata,
    input  logic [QCOUNT_W-1:0]               i_q_count,
    input  logic                              i_back_busy,
    output logic                              o_push,
    output t_job                              o_job,
    output logic signed [sum_width(MAX_PIXELS)-1:0] o_sum_before,
    output logic signed [sum_width(MAX_PIXELS)-1:0] o_sum_after
);

    localparam int SUM_W = sum_width(MAX_PIXELS);
    localparam int AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW    = $clog2(MAX_PIXELS + 1);

    t_mag                    r_store [MAX_PIXELS];
    logic [CW-1:0]           r_load_count, n_load_count;
    logic [CW-1:0]           r_drain_index, n_drain_index;
    logic                    r_complete, n_complete;
    logic signed [SUM_W-1:0] r_sum_before, n_sum_before;
    logic signed [SUM_W-1:0] r_sum_after, n_sum_after;
    logic                    r_norm_en;
    logic                    r_rd_valid, n_rd_valid;
    logic                    r_rd_last, n_rd_last;
    logic                    r_rd_scale, n_rd_scale;
    t_mag                    r_rd_data;

    logic                    load_block, drain_block;
    logic [QCOUNT_W:0]       q_used;
    logic                    accept, load_acc, drain_acc, drain_ok;
    logic [CW-1:0]           base_count;
    logic signed [SUM_W-1:0] base_before, base_after;
    logic                    room;
    logic signed [SUM_W-1:0] pix_sext;
    t_mag                    clamped;
    logic                    store_we;

    // a load waits until every earlier drain has left the back
    assign load_block = r_rd_valid | (i_q_count != '0) | i_back_busy;
    // a drain needs a free queue slot, counting the one in the read stage
    assign q_used      = {1'b0, i_q_count} + {{QCOUNT_W{1'b0}}, r_rd_valid};
    assign drain_block = q_used >= (QCOUNT_W + 1)'(QUEUE_DEPTH);
    assign o_in_stall  = (i_operation == OP_LOAD) ? load_block : drain_block;

    assign accept    = i_in_valid & ~o_in_stall;
    assign load_acc  = accept & (i_operation == OP_LOAD);
    assign drain_acc = accept & (i_operation == OP_DRAIN);
    assign drain_ok  = r_complete && (r_drain_index < r_load_count);

    // a load after a complete image starts a new one
    assign base_count  = r_complete ? '0 : r_load_count;
    assign base_before = r_complete ? '0 : r_sum_before;
    assign base_after  = r_complete ? '0 : r_sum_after;
    assign room        = base_count < CW'(MAX_PIXELS);

    // sign extension and clamp of the incoming pixel
    assign pix_sext = {{(SUM_W-PIXEL_BITS){i_pixel_value[PIXEL_BITS-1]}}, i_pixel_value};
    assign clamped  = i_pixel_value[PIXEL_BITS-1] ? '0 : i_pixel_value[PIXEL_BITS-2:0];
    assign store_we = load_acc & room;

    // next state of counters and sums
    always_comb begin
        n_load_count  = r_load_count;
        n_drain_index = r_drain_index;
        n_complete    = r_complete;
        n_sum_before  = r_sum_before;
        n_sum_after   = r_sum_after;
        n_rd_valid    = 1'b0;
        n_rd_last     = r_rd_last;
        n_rd_scale    = r_rd_scale;
        if (load_acc) begin
            n_load_count  = base_count;
            n_drain_index = r_complete ? '0 : r_drain_index;
            n_complete    = 1'b0;
            n_sum_before  = base_before;
            n_sum_after   = base_after;
            if (room) begin
                n_sum_before = base_before + pix_sext;
                n_sum_after  = base_after + SUM_W'(clamped);
                n_load_count = base_count + 1'b1;
            end
            if (i_is_last) begin
                n_complete = 1'b1;
            end
        end else if (drain_acc && drain_ok) begin
            n_rd_valid    = 1'b1;
            n_rd_last     = (r_drain_index + 1'b1) == r_load_count;
            n_rd_scale    = r_norm_en && (r_sum_after != '0);
            n_drain_index = r_drain_index + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count  <= '0;
            r_drain_index <= '0;
            r_complete    <= 1'b0;
            r_sum_before  <= '0;
            r_sum_after   <= '0;
            r_norm_en     <= 1'b0;
            r_rd_valid    <= 1'b0;
        end else begin
            r_load_count  <= n_load_count;
            r_drain_index <= n_drain_index;
            r_complete    <= n_complete;
            r_sum_before  <= n_sum_before;
            r_sum_after   <= n_sum_after;
            r_rd_valid    <= n_rd_valid;
            if (i_cfg_we) begin
                r_norm_en <= i_cfg_wdata;
            end
        end
    end

    // job flags follow the read stage
    always_ff @(posedge i_clk) begin
        r_rd_last  <= n_rd_last;
        r_rd_scale <= n_rd_scale;
    end

    // pixel store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[base_count[AW-1:0]] <= clamped;
        end
        if (drain_acc && drain_ok) begin
            r_rd_data <= r_store[r_drain_index[AW-1:0]];
        end
    end

    assign o_push       = r_rd_valid;
    assign o_job        = '{pixel: r_rd_data, last: r_rd_last, scale: r_rd_scale};
    assign o_sum_before = r_sum_before;
    assign o_sum_after  = r_sum_after;

endmodule

[rtl/cnr_back.sv]
// output side: rescales drained pixels with a bit-serial divider
module cnr_back
    import cnr_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_job_valid,
    input  t_job                                    i_job,
    output logic                                    o_pop,
    output logic                                    o_busy,
    input  logic signed [sum_width(MAX_PIXELS)-1:0] i_sum_before,
    input  logic signed [sum_width(MAX_PIXELS)-1:0] i_sum_after,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output t_pixel                                  o_result_pixel,
    output logic                                    o_last_out
);

    localparam int SUM_W = sum_width(MAX_PIXELS);
    // product width, and one more bit for the range check
    localparam int PW    = PIXEL_BITS - 1 + SUM_W;
    localparam int DW    = PW + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]            r_state, n_state;
    t_mag                  r_pixel, n_pixel;
    logic                  r_last, n_last;
    logic                  r_scale, n_scale;
    logic                  r_neg, n_neg;
    logic                  r_ovf, n_ovf;
    logic [PW-1:0]         r_rem, n_rem;
    logic [PW-1:0]         r_dsh, n_dsh;
    logic [PIXEL_BITS-1:0] r_q, n_q;
    logic [STEP_W-1:0]     r_step, n_step;
    logic                  r_out_valid, n_out_valid;
    logic [PIXEL_BITS-1:0] r_result, n_result;
    logic                  r_out_last, n_out_last;

    logic [SUM_W-1:0]      mag;
    logic [DW-1:0]         div_top;
    logic                  rem_ge;
    logic                  out_free;
    logic [PIXEL_BITS-1:0] sat_value;

    // magnitude of the signed numerator
    assign mag      = i_sum_before[SUM_W-1] ? (~i_sum_before + 1'b1) : i_sum_before;
    // divisor shifted to the first quotient bit beyond the output range
    assign div_top  = {i_sum_after, {PIXEL_BITS{1'b0}}};
    assign rem_ge   = r_rem >= r_dsh;
    assign out_free = ~r_out_valid | ~i_out_stall;

    // truncated quotient saturated to the signed pixel range, or the pixel as is when not rescaled
    always_comb begin
        if (!r_scale) begin
            sat_value = {1'b0, r_pixel};
        end else if (r_neg) begin
            sat_value = (r_ovf || (r_q > PIX_MIN)) ? PIX_MIN : (~r_q + 1'b1);
        end else begin
            sat_value = (r_ovf || (r_q > PIX_MAX)) ? PIX_MAX : r_q;
        end
    end

    // sequencer: multiply, range check, one quotient bit per cycle
    always_comb begin
        n_state     = r_state;
        n_pixel     = r_pixel;
        n_last      = r_last;
        n_scale     = r_scale;
        n_neg       = r_neg;
        n_ovf       = r_ovf;
        n_rem       = r_rem;
        n_dsh       = r_dsh;
        n_q         = r_q;
        n_step      = r_step;
        n_out_valid = r_out_valid & i_out_stall;
        n_result    = r_result;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_pixel = i_job.pixel;
                    n_last  = i_job.last;
                    n_scale = i_job.scale;
                    n_ovf   = 1'b0;
                    n_state = i_job.scale ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL: begin
                n_neg   = i_sum_before[SUM_W-1];
                n_rem   = {{SUM_W{1'b0}}, r_pixel} * {{(PIXEL_BITS-1){1'b0}}, mag};
                n_state = ST_CHK;
            end
            ST_CHK: begin
                n_q    = '0;
                n_dsh  = {i_sum_after, {(PIXEL_BITS-1){1'b0}}};
                n_step = STEP_W'(PIXEL_BITS - 1);
                if ({1'b0, r_rem} >= div_top) begin
                    n_ovf   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (rem_ge) begin
                    n_rem = r_rem - r_dsh;
                end
                n_q   = {r_q[PIXEL_BITS-2:0], rem_ge};
                n_dsh = r_dsh >> 1;
                if (r_step == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_result    = sat_value;
                    n_out_last  = r_last;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_pixel    <= n_pixel;
        r_last     <= n_last;
        r_scale    <= n_scale;
        r_neg      <= n_neg;
        r_ovf      <= n_ovf;
        r_rem      <= n_rem;
        r_dsh      <= n_dsh;
        r_q        <= n_q;
        r_step     <= n_step;
        r_result   <= n_result;
        r_out_last <= n_out_last;
    end

    assign o_busy         = r_state != ST_IDLE;
    assign o_out_valid    = r_out_valid;
    assign o_result_pixel = r_result;
    assign o_last_out     = r_out_last;

endmodule

[rtl/clamp_negative_renormalize.sv]
// top level of the clamp and renormalize block
// Load transfers (operation 0) write one pixel per cycle, unless stalled,
// into the on-chip store, with negative values clamped to zero, while the
// raw and clamped sums are accumulated; the pixel flagged is_last completes
// the image. A load after a complete image starts a new one, and a load
// waits while any drain is still in flight. Drain transfers (operation 1)
// read the store in load order, one per cycle while the queue has room, into
// a four-entry job queue; a drain before the image is complete or past its
// last pixel gives no result. Each drained pixel passes the back end
// unchanged when normalize_enable is clear or the clamped sum is zero, and
// is otherwise rescaled to pixel*sum_before/sum_after by the restoring
// divider, which produces one quotient bit per cycle; a rescale whose
// product already shows a quotient wider than PIXEL_BITS bits saturates
// without dividing. The store needs no clearing after reset. The user is to
// write normalize_enable only while the block is idle; it is not enforced.
module clamp_negative_renormalize
    import cnr_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_stall,
    input  logic   i_operation,
    input  t_pixel i_pixel_value,
    input  logic   i_is_last,
    output logic   o_out_valid,
    input  logic   i_out_stall,
    output t_pixel o_result_pixel,
    output logic   o_last_out,
    input  logic   i_cfg_we,
    input  logic   i_cfg_wdata
);

    localparam int SUM_W = sum_width(MAX_PIXELS);

    logic                    push, pop, back_busy;
    t_job                    push_job, pop_job;
    logic [QCOUNT_W-1:0]     q_count;
    logic signed [SUM_W-1:0] sum_before, sum_after;

    // load handling and drain issue
    cnr_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_pixel_value (i_pixel_value),
        .i_is_last     (i_is_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_count     (q_count),
        .i_back_busy   (back_busy),
        .o_push        (push),
        .o_job         (push_job),
        .o_sum_before  (sum_before),
        .o_sum_after   (sum_after)
    );

    // decoupling queue
    cnr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_count (q_count)
    );

    // rescale and output register
    cnr_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_count != '0),
        .i_job          (pop_job),
        .o_pop          (pop),
        .o_busy         (back_busy),
        .i_sum_before   (sum_before),
        .i_sum_after    (sum_after),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_pixel (o_result_pixel),
        .o_last_out     (o_last_out)
    );

endmodule
